### sv/kstf_pkg.sv
// Shared types, codes and constants of the keyboard scancode translator.
`default_nettype none
package kstf_pkg;

  // Default sizes of the stores.
  localparam int FifoDepthDefault = 16;
  localparam int KeyCountDefault  = 90;

  // Fixed field widths.
  localparam int ReqW      = 3;
  localparam int CodeW     = 8;
  localparam int KeyW      = 7;
  localparam int MapSelW   = 3;
  localparam int ResultW   = 16;
  localparam int EntriesW  = 5;
  // Width that holds every position, count and entry limit for comparisons.
  localparam int PosCmpW   = 9;
  // Width that holds any keymap address before it is cut to the memory's size.
  localparam int KmCalcW   = 10;
  // Number of key-state bits seen through the widest key index.
  localparam int KeyVecW   = 128;

  // Command queue between front and back.
  localparam int QDepth    = 2;

  // Request codes.
  localparam logic [ReqW-1:0] ReqScan     = 3'd0;
  localparam logic [ReqW-1:0] ReqRead     = 3'd1;
  localparam logic [ReqW-1:0] ReqPeek     = 3'd2;
  localparam logic [ReqW-1:0] ReqShift    = 3'd3;
  localparam logic [ReqW-1:0] ReqKeyState = 3'd4;
  localparam logic [ReqW-1:0] ReqMapWrite = 3'd5;

  // Keymap numbers.
  localparam logic [MapSelW-1:0] MapPlain = 3'd0;
  localparam logic [MapSelW-1:0] MapShift = 3'd1;
  localparam logic [MapSelW-1:0] MapCaps  = 3'd2;
  localparam logic [MapSelW-1:0] MapCtrl  = 3'd3;
  localparam logic [MapSelW-1:0] MapAlt   = 3'd4;
  localparam int                 MapCount = 5;

  // Modifier keys and translation constants.
  localparam logic [KeyW-1:0]  KeyAlt     = 7'h38;
  localparam logic [KeyW-1:0]  KeyCtrl    = 7'h1D;
  localparam logic [KeyW-1:0]  KeyLShift  = 7'h2A;
  localparam logic [KeyW-1:0]  KeyRShift  = 7'h36;
  localparam logic [KeyW-1:0]  KeyCaps    = 7'h3A;
  localparam logic [CodeW-1:0] KeyLimit   = 8'h5A;
  localparam int               BreakBit   = 7;
  localparam logic [CodeW-1:0] ExtMaskMin = 8'h85;
  localparam logic [CodeW-1:0] LowMask    = 8'h7F;
  localparam logic [CodeW-1:0] ExtFlag    = 8'h80;

  localparam logic [EntriesW-1:0] EntriesReset = 5'd16;

  // Classified operations carried from front to back.
  typedef enum logic [2:0] {
    OP_MAKE,
    OP_BREAK,
    OP_READ,
    OP_PEEK,
    OP_SHIFT,
    OP_KEYSTATE,
    OP_MAPWR,
    OP_UNKNOWN
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [KeyW-1:0]    key;
    logic [MapSelW-1:0] map_sel;
    logic [CodeW-1:0]   map_value;
    logic               wr_ok;
  } cmd_t;

  // Back status seen by the top level.
  typedef struct packed {
    logic               busy;
    logic [PosCmpW-1:0] fill;
  } back_status_t;

  // Translated key code from a keymap byte.
  function automatic logic [ResultW-1:0] translate(input logic [CodeW-1:0] v);
    logic [CodeW-1:0] m;
    m = v;
    if ((v & ExtFlag) != '0) begin
      if (v >= ExtMaskMin) m = v & LowMask;
      translate = {m, 8'h00};
    end else begin
      translate = {8'h00, v};
    end
  endfunction

endpackage
`default_nettype wire

### sv/keyboard_scancode_translate_fifo.sv
// Top level of the keyboard scancode translator with its key-code ring buffer.
//
// Requests enter on a valid/ready channel: scancodes, read key, peek key,
// shift status, key state and keymap loads. A make code translates through
// one of five keymaps chosen by held modifier and is pushed into the ring
// buffer; a break code releases the key. Read, peek, shift status, key state
// and unknown requests each give one result beat on the output channel.
// The entry count of the ring is written through the APB port at address 0.
// Each beat passes a decode stage into a two-entry command queue, so the
// front keeps taking beats while the back works. The back sequencer handles
// a make code or a result request in its idle and exec states (memory read,
// then push or retire) and a break code or a keymap load in its idle state
// alone, as the keymap and ring memory read ports are registered. A result
// passes the command queue and both sequencer states to the output register.
// While the receiver holds out_ready low the finished result stays in the
// output register, the back stalls on the next result request and the
// queue then fills, lowering in_ready. Reset clears all key-down bits, the
// ring positions and its fill count and sets the entry count to 16; keymap
// and ring contents are undefined until written.
`default_nettype none
module keyboard_scancode_translate_fifo #(
  parameter int FIFO_DEPTH = kstf_pkg::FifoDepthDefault,
  parameter int KEY_COUNT  = kstf_pkg::KeyCountDefault
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [kstf_pkg::ReqW-1:0]      req_type,
  input  wire logic [kstf_pkg::CodeW-1:0]     scancode,
  input  wire logic [kstf_pkg::KeyW-1:0]      key_index,
  input  wire logic [kstf_pkg::MapSelW-1:0]   map_select,
  input  wire logic [kstf_pkg::CodeW-1:0]     map_value,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic      [kstf_pkg::ResultW-1:0]   result_value,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [2:0]                     paddr,
  input  wire logic [31:0]                    pwdata,
  output logic      [31:0]                    prdata,
  output logic                                pready
);

  logic                              q_full;
  logic                              q_push;
  logic                              q_pop;
  logic                              q_valid;
  kstf_pkg::cmd_t                    front_cmd;
  kstf_pkg::cmd_t                    q_head;
  kstf_pkg::back_status_t            back_status;
  logic [kstf_pkg::EntriesW-1:0]     buffer_entries;
  logic                              reg_sel;

  // Configuration register.
  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == 1'b0);
  assign prdata  = reg_sel ? 32'(buffer_entries) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_entries <= kstf_pkg::EntriesReset;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      buffer_entries <= pwdata[kstf_pkg::EntriesW-1:0];
    end
  end

  kstf_front #(
    .KEY_COUNT (KEY_COUNT)
  ) u_front (
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .req_type   (req_type),
    .scancode   (scancode),
    .key_index  (key_index),
    .map_select (map_select),
    .map_value  (map_value),
    .q_full     (q_full),
    .push       (q_push),
    .cmd        (front_cmd)
  );

  kstf_cmd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (front_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .head     (q_head)
  );

  kstf_back #(
    .FIFO_DEPTH (FIFO_DEPTH),
    .KEY_COUNT  (KEY_COUNT)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .q_valid        (q_valid),
    .q_cmd          (q_head),
    .pop            (q_pop),
    .buffer_entries (buffer_entries),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .result_value   (result_value),
    .status         (back_status)
  );

  // The ring never holds more codes than its depth.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    back_status.fill <= kstf_pkg::PosCmpW'(FIFO_DEPTH))
    else $error("ring fill count exceeds its depth");

  // Reset leaves the back idle with an empty ring.
  a_reset_clear: assert property (@(posedge clk)
    rst |=> (back_status.fill == '0) && !back_status.busy && !out_valid)
    else $error("back not cleared by reset");

  // The back never takes a command while it is still working on one.
  a_no_pop_busy: assert property (@(posedge clk) disable iff (rst)
    back_status.busy |-> !q_pop)
    else $error("command taken while sequencer busy");

endmodule
`default_nettype wire

### sv/kstf_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module kstf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

### sv/kstf_front.sv
// Front end: accepts request beats and classifies them into commands.
`default_nettype none
module kstf_front #(
  parameter int KEY_COUNT = kstf_pkg::KeyCountDefault
) (
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [kstf_pkg::ReqW-1:0]     req_type,
  input  wire logic [kstf_pkg::CodeW-1:0]    scancode,
  input  wire logic [kstf_pkg::KeyW-1:0]     key_index,
  input  wire logic [kstf_pkg::MapSelW-1:0]  map_select,
  input  wire logic [kstf_pkg::CodeW-1:0]    map_value,
  input  wire logic                          q_full,
  output logic                               push,
  output kstf_pkg::cmd_t                     cmd
);

  logic [kstf_pkg::KeyW-1:0] scan_key;

  // Accept whenever the queue has room.
  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

  // Key number of a scancode; keys past the table count as key 0.
  always_comb begin
    scan_key = scancode[kstf_pkg::KeyW-1:0];
    if ({1'b0, scan_key} >= kstf_pkg::KeyLimit ||
        {1'b0, scan_key} >= kstf_pkg::CodeW'(KEY_COUNT)) begin
      scan_key = '0;
    end
  end

  // Request decode.
  always_comb begin
    cmd.key       = key_index;
    cmd.map_sel   = map_select;
    cmd.map_value = map_value;
    cmd.wr_ok     = (map_select < kstf_pkg::MapSelW'(kstf_pkg::MapCount)) &&
                    ({1'b0, key_index} < kstf_pkg::CodeW'(KEY_COUNT));
    unique case (req_type)
      kstf_pkg::ReqScan: begin
        cmd.key = scan_key;
        cmd.op  = scancode[kstf_pkg::BreakBit] ? kstf_pkg::OP_BREAK : kstf_pkg::OP_MAKE;
      end
      kstf_pkg::ReqRead:     cmd.op = kstf_pkg::OP_READ;
      kstf_pkg::ReqPeek:     cmd.op = kstf_pkg::OP_PEEK;
      kstf_pkg::ReqShift:    cmd.op = kstf_pkg::OP_SHIFT;
      kstf_pkg::ReqKeyState: cmd.op = kstf_pkg::OP_KEYSTATE;
      kstf_pkg::ReqMapWrite: cmd.op = kstf_pkg::OP_MAPWR;
      default:               cmd.op = kstf_pkg::OP_UNKNOWN;
    endcase
  end

endmodule
`default_nettype wire

### sv/kstf_cmd_queue.sv
// Short command queue that decouples the front end from the back end.
`default_nettype none
module kstf_cmd_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire kstf_pkg::cmd_t push_cmd,
  output logic                full,
  input  wire logic           pop,
  output logic                valid,
  output kstf_pkg::cmd_t      head
);

  localparam int PW = (kstf_pkg::QDepth > 1) ? $clog2(kstf_pkg::QDepth) : 1;
  localparam int CW = $clog2(kstf_pkg::QDepth + 1);

  kstf_pkg::cmd_t entries [kstf_pkg::QDepth];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;

  assign full  = (count == CW'(kstf_pkg::QDepth));
  assign valid = (count != '0);
  assign head  = entries[rd_ptr];

  // Pointer and count update.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(kstf_pkg::QDepth - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(kstf_pkg::QDepth - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) count <= count + CW'(1);
      else if (pop && !push) count <= count - CW'(1);
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_cmd;
  end

endmodule
`default_nettype wire

### sv/kstf_back.sv
// Back end: key state, keymap translation, key-code ring buffer and results.
`default_nettype none
module kstf_back #(
  parameter int FIFO_DEPTH = kstf_pkg::FifoDepthDefault,
  parameter int KEY_COUNT  = kstf_pkg::KeyCountDefault
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            q_valid,
  input  wire kstf_pkg::cmd_t                  q_cmd,
  output logic                                 pop,
  input  wire logic [kstf_pkg::EntriesW-1:0]   buffer_entries,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic      [kstf_pkg::ResultW-1:0]    result_value,
  output kstf_pkg::back_status_t               status
);

  localparam int PW   = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CW   = $clog2(FIFO_DEPTH + 1);
  localparam int KIW  = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
  localparam int KMD  = kstf_pkg::MapCount * KEY_COUNT;
  localparam int KMAW = (KMD > 1) ? $clog2(KMD) : 1;
  localparam int NW   = kstf_pkg::PosCmpW;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic                              state;
  logic                              state_next;
  kstf_pkg::cmd_t                    cmd_q;
  logic [KEY_COUNT-1:0]              key_down;
  logic [KEY_COUNT-1:0]              key_down_next;
  logic [PW-1:0]                     write_pos;
  logic [PW-1:0]                     write_pos_next;
  logic [PW-1:0]                     read_pos;
  logic [PW-1:0]                     read_pos_next;
  logic [CW-1:0]                     fill_count;
  logic [CW-1:0]                     fill_count_next;
  logic                              out_valid_next;
  logic [kstf_pkg::ResultW-1:0]      result_next;
  logic [kstf_pkg::KeyVecW-1:0]      key_vec;
  logic [kstf_pkg::KeyVecW-1:0]      make_vec;
  logic [kstf_pkg::MapSelW-1:0]      map_pick;
  logic [kstf_pkg::KmCalcW-1:0]      km_rd_calc;
  logic [kstf_pkg::KmCalcW-1:0]      km_wr_calc;
  logic                              km_rd_en;
  logic                              km_wr_en;
  logic [kstf_pkg::CodeW-1:0]        km_rd_data;
  logic                              fifo_wr_en;
  logic [kstf_pkg::ResultW-1:0]      fifo_wr_data;
  logic                              fifo_rd_en;
  logic [kstf_pkg::ResultW-1:0]      fifo_rd_data;
  logic [NW-1:0]                     entries_used;
  logic [NW-1:0]                     wp_inc;
  logic [NW-1:0]                     rp_inc;
  logic [NW-1:0]                     fill_inc;
  logic [PW-1:0]                     wp_adv;
  logic [PW-1:0]                     rp_adv;
  logic                              has_result;
  logic                              out_free;

  // Key-down bits seen through a full seven-bit key number; keys past the
  // table read as released.
  always_comb begin
    key_vec = '0;
    key_vec[KEY_COUNT-1:0] = key_down;
    make_vec = key_vec;
    make_vec[q_cmd.key] = 1'b1;
  end

  // Keymap choice by held modifier, with the new key already counted as held.
  always_comb begin
    if (make_vec[kstf_pkg::KeyAlt])                                   map_pick = kstf_pkg::MapAlt;
    else if (make_vec[kstf_pkg::KeyCtrl])                             map_pick = kstf_pkg::MapCtrl;
    else if (make_vec[kstf_pkg::KeyLShift] || make_vec[kstf_pkg::KeyRShift])
      map_pick = kstf_pkg::MapShift;
    else if (make_vec[kstf_pkg::KeyCaps])                             map_pick = kstf_pkg::MapCaps;
    else                                                              map_pick = kstf_pkg::MapPlain;
  end

  // Keymap addresses for a translation read and for a table load.
  always_comb begin
    km_rd_calc = kstf_pkg::KmCalcW'(map_pick) * kstf_pkg::KmCalcW'(KEY_COUNT) +
                 kstf_pkg::KmCalcW'(q_cmd.key);
    km_wr_calc = kstf_pkg::KmCalcW'(q_cmd.map_sel) * kstf_pkg::KmCalcW'(KEY_COUNT) +
                 kstf_pkg::KmCalcW'(q_cmd.key);
  end

  // Clamped entry count and wrapped position advances.
  always_comb begin
    entries_used = NW'(buffer_entries);
    if (entries_used == '0) entries_used = NW'(1);
    else if (entries_used > NW'(FIFO_DEPTH)) entries_used = NW'(FIFO_DEPTH);
    wp_inc   = NW'(write_pos) + NW'(1);
    rp_inc   = NW'(read_pos) + NW'(1);
    fill_inc = NW'(fill_count) + NW'(1);
    wp_adv   = (wp_inc >= entries_used) ? '0 : PW'(wp_inc);
    rp_adv   = (rp_inc >= entries_used) ? '0 : PW'(rp_inc);
  end

  assign out_free   = !out_valid || out_ready;
  assign has_result = (cmd_q.op != kstf_pkg::OP_MAKE);
  assign pop        = (state == S_IDLE) && q_valid;

  // Sequencer: the idle state takes a command, updates key state or loads the keymap
  // and starts any memory read; the exec state finishes the push or retires the result.
  always_comb begin
    state_next      = state;
    key_down_next   = key_down;
    write_pos_next  = write_pos;
    read_pos_next   = read_pos;
    fill_count_next = fill_count;
    out_valid_next  = out_valid && !out_ready;
    result_next     = result_value;
    km_rd_en        = 1'b0;
    km_wr_en        = 1'b0;
    fifo_rd_en      = 1'b0;
    fifo_wr_en      = 1'b0;
    fifo_wr_data    = kstf_pkg::translate(km_rd_data);
    unique case (state)
      S_IDLE: begin
        if (q_valid) begin
          case (q_cmd.op)
            kstf_pkg::OP_MAKE: begin
              key_down_next[q_cmd.key[KIW-1:0]] = 1'b1;
              km_rd_en   = 1'b1;
              state_next = S_EXEC;
            end
            kstf_pkg::OP_BREAK: key_down_next[q_cmd.key[KIW-1:0]] = 1'b0;
            kstf_pkg::OP_MAPWR: km_wr_en = q_cmd.wr_ok;
            default: begin
              fifo_rd_en = 1'b1;
              state_next = S_EXEC;
            end
          endcase
        end
      end
      S_EXEC: begin
        if (!has_result) begin
          // Push the translated code; a full ring drops its oldest entry.
          fifo_wr_en     = 1'b1;
          write_pos_next = wp_adv;
          state_next     = S_IDLE;
          if (fill_inc > entries_used) begin
            fill_count_next = CW'(entries_used);
            read_pos_next   = wp_adv;
          end else begin
            fill_count_next = CW'(fill_inc);
          end
        end else if (out_free) begin
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
          case (cmd_q.op)
            kstf_pkg::OP_READ: begin
              result_next = (fill_count != '0) ? fifo_rd_data : '0;
              if (fill_count != '0) begin
                read_pos_next   = rp_adv;
                fill_count_next = fill_count - CW'(1);
              end
            end
            kstf_pkg::OP_PEEK: result_next = (fill_count != '0) ? fifo_rd_data : '0;
            kstf_pkg::OP_SHIFT: begin
              result_next = kstf_pkg::ResultW'(key_vec[kstf_pkg::KeyLShift] |
                                               key_vec[kstf_pkg::KeyRShift]);
            end
            kstf_pkg::OP_KEYSTATE: result_next = kstf_pkg::ResultW'(key_vec[cmd_q.key]);
            default: result_next = '0;
          endcase
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      key_down   <= '0;
      write_pos  <= '0;
      read_pos   <= '0;
      fill_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      key_down   <= key_down_next;
      write_pos  <= write_pos_next;
      read_pos   <= read_pos_next;
      fill_count <= fill_count_next;
      out_valid  <= out_valid_next;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    result_value <= result_next;
    if (pop) cmd_q <= q_cmd;
  end

  assign status.busy = (state == S_EXEC);
  assign status.fill = NW'(fill_count);

  // Five keymaps, one after another.
  kstf_ram #(
    .WIDTH (kstf_pkg::CodeW),
    .DEPTH (KMD)
  ) u_keymap_ram (
    .clk     (clk),
    .wr_en   (km_wr_en),
    .wr_addr (KMAW'(km_wr_calc)),
    .wr_data (q_cmd.map_value),
    .rd_en   (km_rd_en),
    .rd_addr (KMAW'(km_rd_calc)),
    .rd_data (km_rd_data)
  );

  // Ring buffer of translated key codes.
  kstf_ram #(
    .WIDTH (kstf_pkg::ResultW),
    .DEPTH (FIFO_DEPTH)
  ) u_fifo_ram (
    .clk     (clk),
    .wr_en   (fifo_wr_en),
    .wr_addr (write_pos),
    .wr_data (fifo_wr_data),
    .rd_en   (fifo_rd_en),
    .rd_addr (read_pos),
    .rd_data (fifo_rd_data)
  );

endmodule
`default_nettype wire
